### sv/mtmu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmu_pkg
// Sizes, codes, request types and the tanh table builder.
// ----------------------------------------------------------------------------
package mtmu_pkg;

	localparam int N_INPUTS   = 21;
	localparam int N_HIDDEN   = 16;
	localparam int N_OUTPUTS  = 6;
	localparam int TANH_DEPTH = 1024;

	localparam int DW      = 24;
	localparam int AV_W    = 18;
	localparam int SLOT_W  = 9;
	localparam int REW_W   = 25;
	localparam int CFG_W   = 16;
	localparam int OIDX_W  = 6;

	localparam int W1_CNT  = N_INPUTS * N_HIDDEN;
	localparam int W2_BASE = W1_CNT;
	localparam int W2_CNT  = N_HIDDEN * N_OUTPUTS;
	localparam int B1_BASE = W2_BASE + W2_CNT;
	localparam int B2_BASE = B1_BASE + N_HIDDEN;
	localparam int W_TOTAL = B2_BASE + N_OUTPUTS;
	localparam int V_TOTAL = W1_CNT + W2_CNT;

	localparam int AW     = $clog2(W_TOTAL);
	localparam int VAW    = $clog2(V_TOTAL);
	localparam int IN_W   = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
	localparam int HID_W  = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
	localparam int OUT_W  = (N_OUTPUTS > 1) ? $clog2(N_OUTPUTS) : 1;
	localparam int TIW    = $clog2(TANH_DEPTH);
	localparam int SUM_W  = (IN_W > HID_W) ? IN_W : HID_W;
	localparam int ACC_W  = 2 * DW + 2 + SUM_W;

	localparam int ONE_Q16   = 65536;
	localparam int W_LIMIT   = 3276800;
	localparam int TENTH_Q16 = 6554;

	localparam int Q_DEPTH = 2;
	localparam int QPW     = 1;

	localparam int CFG_IW = 1;
	localparam logic [CFG_IW-1:0] CFG_LEARN_RATE = 1'b0;
	localparam logic [CFG_IW-1:0] CFG_MOMENTUM   = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_FEATURE = 2'd1,
		OP_LEARN   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_FEATURE,
		CMD_LEARN
	} cmd_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic                     last;
		logic [SLOT_W-1:0]        slot;
		logic signed [DW-1:0]     value;
		logic signed [REW_W-1:0]  reward;
	} cmd_entry_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	// shift-subtract quotient, elaboration only
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(65536*tanh(8k/DEPTH)) through e^-2x in Q30, elaboration only
	function automatic logic [16:0] tanh_entry(input int k);
		longint unsigned t, n, f, sum, term, e, num, den, i;
		t = ((64'd16 * 64'(k)) << 30) >> TIW;
		n = t >> 30;
		f = t & 64'h3FFF_FFFF;
		sum = 64'd1073741824;
		term = 64'd1073741824;
		for (i = 1; i < 40 && term != 0; i++) begin
			term = udiv64((term * f) >> 30, i);
			if (i[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		e = sum;
		for (i = 0; i < n; i++)
			e = (e * 64'd395007542) >> 30;
		num = (64'd1073741824 - e) << 16;
		den = 64'd1073741824 + e;
		return 17'(udiv64(num + (den >> 1), den));
	endfunction

endpackage

### sv/mtmu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmu_item_if / mtmu_result_if
// Valid/ready channels for input requests and network results.
// ----------------------------------------------------------------------------
interface mtmu_item_if;
	logic                                    valid;
	logic                                    ready;
	logic [1:0]                              operation;
	logic [mtmu_pkg::SLOT_W-1:0]             slot;
	logic signed [mtmu_pkg::DW-1:0]          value;
	logic signed [mtmu_pkg::REW_W-1:0]       reward;

	modport source (output valid, operation, slot, value, reward, input ready);
	modport sink   (input valid, operation, slot, value, reward, output ready);
endinterface

interface mtmu_result_if;
	logic                                    valid;
	logic                                    ready;
	logic [mtmu_pkg::OIDX_W-1:0]             out_index;
	logic signed [mtmu_pkg::AV_W-1:0]        out_value;
	logic                                    last_out;

	modport source (output valid, out_index, out_value, last_out, input ready);
	modport sink   (input valid, out_index, out_value, last_out, output ready);
endinterface

### sv/mtmu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmu_front
// Accepts requests, drops meaningless ones and queues the rest as commands.
// ----------------------------------------------------------------------------
module mtmu_front (
	mtmu_item_if.sink              in_ch,
	input  logic                   q_full,
	input  mtmu_pkg::back_stat_t   stat,
	output logic                   push,
	output mtmu_pkg::cmd_entry_t   entry
);
	import mtmu_pkg::*;

	logic keep;

	assign in_ch.ready = !q_full && !stat.clearing;

	always_comb begin
		keep         = 1'b0;
		entry.cmd    = CMD_LOAD;
		entry.last   = 1'b0;
		entry.slot   = in_ch.slot;
		entry.value  = in_ch.value;
		entry.reward = in_ch.reward;
		if (in_ch.operation == OP_LOAD) begin
			keep = 32'(in_ch.slot) < W_TOTAL;
		end else if (in_ch.operation == OP_FEATURE) begin
			keep       = 32'(in_ch.slot) < N_INPUTS;
			entry.cmd  = CMD_FEATURE;
			entry.last = 32'(in_ch.slot) == N_INPUTS - 1;
		end else if (in_ch.operation == OP_LEARN) begin
			keep      = 1'b1;
			entry.cmd = CMD_LEARN;
		end
	end

	assign push = in_ch.valid && in_ch.ready && keep;

endmodule

### sv/mtmu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmu_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module mtmu_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  mtmu_pkg::cmd_entry_t   push_entry,
	input  logic                   pop,
	output mtmu_pkg::cmd_entry_t   head,
	output logic                   empty,
	output logic                   full
);
	import mtmu_pkg::*;

	cmd_entry_t     mem_q [Q_DEPTH];
	logic [QPW-1:0] wr_q;
	logic [QPW-1:0] rd_q;
	logic [QPW:0]   cnt_q;

	assign empty = cnt_q == '0;
	assign full  = cnt_q == (QPW+1)'(Q_DEPTH);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_entry;
	end

endmodule

### sv/mtmu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmu_back
// Executes commands: weight loads, forward pass with one shared MAC and the
// tanh table, and the momentum weight update, one weight at a time.
// ----------------------------------------------------------------------------
module mtmu_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mtmu_pkg::cmd_entry_t          head,
	input  logic                          empty,
	output logic                          pop,
	output mtmu_pkg::back_stat_t          stat,
	input  logic [mtmu_pkg::CFG_W-1:0]    learn_rate,
	input  logic [mtmu_pkg::CFG_W-1:0]    momentum_factor,
	mtmu_result_if.source                 out_ch
);
	import mtmu_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_BRD, S_BIAS, S_RD, S_MUL, S_ACC,
		S_TIDX, S_TROM, S_TPUT, S_EMIT,
		S_LA, S_LB, S_LC, S_LD, S_LE
	} state_t;

	state_t              state_q;
	logic                layer_q;
	logic [IN_W-1:0]     i_q;
	logic [HID_W-1:0]    h_q;
	logic [OUT_W-1:0]    o_q;
	logic [AW-1:0]       addr_q;
	logic [VAW-1:0]      clr_q;

	logic signed [DW-1:0]   saved_in_q  [N_INPUTS];
	logic signed [AV_W-1:0] saved_hid_q [N_HIDDEN];
	logic signed [AV_W-1:0] saved_out_q [N_OUTPUTS];

	logic                    ov_q;
	logic [OIDX_W-1:0]       oidx_q;
	logic signed [AV_W-1:0]  oval_q;
	logic                    olast_q;

	logic signed [DW-1:0] w_mem   [W_TOTAL];
	logic signed [DW-1:0] vel_mem [V_TOTAL];
	logic signed [DW-1:0] w_rd_q;
	logic signed [DW-1:0] v_rd_q;
	logic [16:0]          tanh_rom [TANH_DEPTH];

	logic signed [ACC_W-1:0]   acc_q;
	logic signed [2*DW-1:0]    prod_q;
	logic                      sat_q;
	logic                      neg_q;
	logic [TIW-1:0]            idx_q;
	logic [16:0]               tab_q;
	logic signed [41:0]        sr_prod_q;
	logic signed [57:0]        prod1_q;
	logic [33:0]               dsq_q;
	logic signed [59:0]        prod2_q;
	logic signed [43:0]        g_q;
	logic signed [40:0]        mv_q;
	logic signed [DW-1:0]      vn_q;

	// combinational helpers
	logic                      w_we;
	logic [AW-1:0]             w_waddr;
	logic signed [DW-1:0]      w_wdata;
	logic                      v_we;
	logic [VAW-1:0]            v_waddr;
	logic signed [DW-1:0]      v_wdata;
	logic signed [DW-1:0]      xv;
	logic signed [ACC_W-17:0]  xs;
	logic [ACC_W-17:0]         xm;
	logic signed [AV_W-1:0]    ty;
	logic signed [AV_W-1:0]    tres;
	logic signed [33:0]        sr;
	logic signed [DW-1:0]      lsrc;
	logic signed [AV_W-1:0]    dsrc;
	logic [16:0]               dmag;
	logic [16:0]               dval;
	logic signed [41:0]        p1;
	logic signed [43:0]        g1;
	logic signed [44:0]        vsum;
	logic signed [DW:0]        wsum;
	logic signed [DW-1:0]      w_new;
	logic                      in_last;
	logic                      hid_last;
	logic                      out_last;

	for (genvar k = 0; k < TANH_DEPTH; k++) begin : g_tab
		localparam logic [16:0] ENTRY = tanh_entry(k);
		assign tanh_rom[k] = ENTRY;
	end

	assign in_last  = i_q == IN_W'(N_INPUTS - 1);
	assign hid_last = h_q == HID_W'(N_HIDDEN - 1);
	assign out_last = o_q == OUT_W'(N_OUTPUTS - 1);

	assign pop            = (state_q == S_IDLE) && !empty;
	assign stat.clearing  = state_q == S_CLEAR;

	assign out_ch.valid     = ov_q;
	assign out_ch.out_index = oidx_q;
	assign out_ch.out_value = oval_q;
	assign out_ch.last_out  = olast_q;

	always_comb begin
		xv   = layer_q ? DW'(saved_hid_q[h_q]) : saved_in_q[i_q];
		xs   = acc_q[ACC_W-1:16];
		xm   = xs[ACC_W-17] ? (ACC_W-16)'(-xs) : (ACC_W-16)'(xs);
		ty   = sat_q ? AV_W'(ONE_Q16) : AV_W'({1'b0, tab_q});
		tres = neg_q ? -ty : ty;
		sr   = sr_prod_q[41:8];
		lsrc = layer_q ? DW'(saved_hid_q[h_q]) : saved_in_q[i_q];
		dsrc = layer_q ? saved_out_q[o_q] : saved_hid_q[h_q];
		dmag = dsrc[AV_W-1] ? 17'(-dsrc) : 17'(dsrc);
		dval = 17'(ONE_Q16 - int'(dsq_q[33:16]));
		p1   = prod1_q[57:16];
		g1   = prod2_q[59:16];
		vsum = 45'($signed(mv_q[40:16])) + 45'(g_q);
		wsum = (DW+1)'(w_rd_q) + (DW+1)'(vn_q);
		if (wsum > (DW+1)'(W_LIMIT))
			w_new = DW'(W_LIMIT);
		else if (wsum < -(DW+1)'(W_LIMIT))
			w_new = -DW'(W_LIMIT);
		else
			w_new = DW'(wsum);
	end

	always_comb begin
		w_we    = 1'b0;
		w_waddr = AW'(head.slot);
		w_wdata = head.value;
		v_we    = 1'b0;
		v_waddr = clr_q;
		v_wdata = '0;
		if (state_q == S_IDLE && !empty && head.cmd == CMD_LOAD) begin
			w_we = 1'b1;
		end else if (state_q == S_LE) begin
			w_we    = 1'b1;
			w_waddr = addr_q;
			w_wdata = w_new;
		end
		if (state_q == S_CLEAR) begin
			v_we = 1'b1;
		end else if (state_q == S_LE) begin
			v_we    = 1'b1;
			v_waddr = VAW'(addr_q);
			v_wdata = vn_q;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we)
			w_mem[w_waddr] <= w_wdata;
		w_rd_q <= w_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (v_we)
			vel_mem[v_waddr] <= v_wdata;
		v_rd_q <= vel_mem[VAW'(addr_q)];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		tab_q <= tanh_rom[idx_q];
		unique case (state_q)
			S_BIAS:  acc_q <= ACC_W'(w_rd_q) <<< 16;
			S_MUL:   prod_q <= xv * w_rd_q;
			S_ACC:   acc_q <= acc_q + ACC_W'(prod_q);
			S_TIDX: begin
				neg_q <= xs[ACC_W-17];
				sat_q <= xm >= (ACC_W-16)'(1 << 19);
				idx_q <= TIW'(xm[18:0] >> (19 - TIW));
			end
			S_IDLE: begin
				sr_prod_q <= head.reward * $signed({1'b0, learn_rate});
			end
			S_LA: begin
				prod1_q <= sr * lsrc;
				dsq_q   <= dmag * dmag;
			end
			S_LB: begin
				prod2_q <= p1 * $signed({1'b0, dval});
				mv_q    <= $signed({1'b0, momentum_factor}) * v_rd_q;
			end
			S_LC: begin
				if (layer_q)
					g_q <= g1;
				else
					g_q <= 44'((58'(g1) * 58'sd6554) >>> 16);
			end
			S_LD: begin
				if (vsum > 45'sd8388607)
					vn_q <= 24'sh7FFFFF;
				else if (vsum < -45'sd8388608)
					vn_q <= 24'sh800000;
				else
					vn_q <= DW'(vsum);
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			layer_q <= 1'b0;
			i_q     <= '0;
			h_q     <= '0;
			o_q     <= '0;
			addr_q  <= '0;
			clr_q   <= '0;
			ov_q    <= 1'b0;
			oidx_q  <= '0;
			oval_q  <= '0;
			olast_q <= 1'b0;
			for (int k = 0; k < N_INPUTS; k++)
				saved_in_q[k] <= '0;
			for (int k = 0; k < N_HIDDEN; k++)
				saved_hid_q[k] <= '0;
			for (int k = 0; k < N_OUTPUTS; k++)
				saved_out_q[k] <= '0;
		end else begin
			if (ov_q && out_ch.ready && state_q != S_EMIT)
				ov_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VAW'(V_TOTAL - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (!empty) begin
						unique case (head.cmd)
							CMD_FEATURE: begin
								saved_in_q[IN_W'(head.slot)] <= head.value;
								if (head.last) begin
									layer_q <= 1'b0;
									i_q     <= '0;
									h_q     <= '0;
									addr_q  <= AW'(B1_BASE);
									state_q <= S_BRD;
								end
							end
							CMD_LEARN: begin
								layer_q <= 1'b1;
								h_q     <= '0;
								o_q     <= '0;
								addr_q  <= AW'(W2_BASE);
								state_q <= S_LA;
							end
							default: ;
						endcase
					end
				end
				S_BRD: state_q <= S_BIAS;
				S_BIAS: begin
					addr_q  <= layer_q ? AW'(W2_BASE + int'(o_q)) : AW'(h_q);
					state_q <= S_RD;
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					addr_q <= addr_q + (layer_q ? AW'(N_OUTPUTS) : AW'(N_HIDDEN));
					if (layer_q) begin
						h_q     <= hid_last ? '0 : h_q + 1'b1;
						state_q <= hid_last ? S_TIDX : S_RD;
					end else begin
						i_q     <= in_last ? '0 : i_q + 1'b1;
						state_q <= in_last ? S_TIDX : S_RD;
					end
				end
				S_TIDX: state_q <= S_TROM;
				S_TROM: state_q <= S_TPUT;
				S_TPUT: begin
					if (layer_q) begin
						saved_out_q[o_q] <= tres;
						state_q          <= S_EMIT;
					end else begin
						saved_hid_q[h_q] <= tres;
						if (hid_last) begin
							layer_q <= 1'b1;
							h_q     <= '0;
							o_q     <= '0;
							addr_q  <= AW'(B2_BASE);
						end else begin
							h_q    <= h_q + 1'b1;
							addr_q <= AW'(B1_BASE + int'(h_q) + 1);
						end
						state_q <= S_BRD;
					end
				end
				S_EMIT: begin
					if (!ov_q || out_ch.ready) begin
						ov_q    <= 1'b1;
						oidx_q  <= OIDX_W'(o_q);
						oval_q  <= saved_out_q[o_q];
						olast_q <= out_last;
						if (out_last) begin
							state_q <= S_IDLE;
						end else begin
							o_q     <= o_q + 1'b1;
							h_q     <= '0;
							addr_q  <= AW'(B2_BASE + int'(o_q) + 1);
							state_q <= S_BRD;
						end
					end
				end
				S_LA: state_q <= S_LB;
				S_LB: state_q <= S_LC;
				S_LC: state_q <= S_LD;
				S_LD: state_q <= S_LE;
				S_LE: begin
					addr_q  <= addr_q + 1'b1;
					state_q <= S_LA;
					if (layer_q) begin
						if (out_last) begin
							o_q <= '0;
							if (hid_last) begin
								layer_q <= 1'b0;
								h_q     <= '0;
								i_q     <= '0;
								addr_q  <= '0;
							end else begin
								h_q <= h_q + 1'b1;
							end
						end else begin
							o_q <= o_q + 1'b1;
						end
					end else begin
						if (hid_last) begin
							h_q <= '0;
							if (in_last) begin
								i_q     <= '0;
								state_q <= S_IDLE;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end else begin
							h_q <= h_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sv/mlp_tanh_infer_momentum_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlp_tanh_infer_momentum_update
// Two-layer tanh perceptron with momentum update, Q8.16 fixed point.
// ----------------------------------------------------------------------------
// in_ch carries load, feature and learn requests; out_ch carries one result
// per network output after the last feature, last_out set on the final one.
// cfg_we/cfg_index/cfg_data write learn_rate (0) and momentum_factor (1).
// The back end handles a load or an ordinary feature in its idle state; a
// two-entry queue lets the front take requests while the back end works.
// Forward pass: one shared multiply-accumulate; each neuron reads its bias,
// then reads, multiplies and accumulates each term, then looks up tanh.
// Learn: every weight of both layers, biases apart, goes through one update
// unit, states S_LA to S_LE in order.
// After reset the velocity memory is cleared, one entry a cycle; in_ch.ready
// stays low until then. Weights are undefined until loaded. A stalled
// receiver holds the result register and halts the forward pass at the next
// output; requests still queue up to two deep.
// ----------------------------------------------------------------------------
module mlp_tanh_infer_momentum_update (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mtmu_pkg::CFG_IW-1:0]          cfg_index,
	input  logic [mtmu_pkg::CFG_W-1:0]           cfg_data,
	mtmu_item_if.sink                            in_ch,
	mtmu_result_if.source                        out_ch
);
	import mtmu_pkg::*;

	logic [CFG_W-1:0] learn_rate_q;
	logic [CFG_W-1:0] momentum_q;
	logic             push;
	logic             pop;
	logic             q_empty;
	logic             q_full;
	cmd_entry_t       push_entry;
	cmd_entry_t       head;
	back_stat_t       stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= 16'd655;
			momentum_q   <= 16'd58982;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEARN_RATE: learn_rate_q <= cfg_data;
				CFG_MOMENTUM:   momentum_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	mtmu_front u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.stat   (stat),
		.push   (push),
		.entry  (push_entry)
	);

	mtmu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	mtmu_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.empty           (q_empty),
		.pop             (pop),
		.stat            (stat),
		.learn_rate      (learn_rate_q),
		.momentum_factor (momentum_q),
		.out_ch          (out_ch)
	);

endmodule

### sv/mtmu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtmu_checker
// Port-level checks on the result channel.
// ----------------------------------------------------------------------------
module mtmu_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [mtmu_pkg::OIDX_W-1:0]         out_index,
	input  logic signed [mtmu_pkg::AV_W-1:0]    out_value,
	input  logic                                last_out
);
	import mtmu_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(out_index) < N_OUTPUTS)
		else $error("output index out of range");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_out == (32'(out_index) == N_OUTPUTS - 1)))
		else $error("last flag on wrong output");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_value <= 18'sd65536 && out_value >= -18'sd65536))
		else $error("tanh value out of range");

endmodule

bind mlp_tanh_infer_momentum_update mtmu_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_index (out_ch.out_index),
	.out_value (out_ch.out_value),
	.last_out  (out_ch.last_out)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tanh perceptron with momentum update.
// ----------------------------------------------------------------------------
// All weights and biases are loaded first. A short table of requests then
// covers the field extremes, ignored requests and learn steps. Random phases
// follow, mostly full feature sweeps with random content, mixed with loads,
// learn requests and junk. Each phase uses its own idle pattern and its own
// register setting. An in-bench network model predicts every result.
// ----------------------------------------------------------------------------
module tb;
	import mtmu_pkg::*;

	localparam logic [1:0] OP_JUNK = 2'd3;
	localparam int QUIET_LIMIT = 30000;
	localparam int SETTLE_CYCLES = 8000;
	localparam int PHASE_REQS = 42;

	typedef struct {
		logic [OIDX_W-1:0]      idx;
		logic signed [AV_W-1:0] val;
		logic                   last;
	} net_out_t;

	typedef struct {
		logic [1:0] op;
		int         slot;
		int         value;
		int         reward;
		bit         zero_out;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	mtmu_item_if in_ch();
	mtmu_result_if out_ch();

	mlp_tanh_infer_momentum_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// network model state
	longint w1[W1_CNT];
	longint w2[W2_CNT];
	longint b1[N_HIDDEN];
	longint b2[N_OUTPUTS];
	longint v1[W1_CNT];
	longint v2[W2_CNT];
	longint x_in[N_INPUTS];
	longint hid[N_HIDDEN];
	longint act[N_OUTPUTS];
	longint rate_q16;
	longint mom_q16;
	int unsigned tanh_lut[TANH_DEPTH];

	net_out_t pending_outputs[$];
	net_out_t fresh_outputs[$];

	int in_idle_pct;
	int out_stall_pct;
	int errors;
	int n_reqs;
	int n_outputs;
	int n_passes;
	int n_learns;
	int quiet;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int unsigned tanh_point(int k);
		longint unsigned t, n, f, acc, term, e, num, den, i;
		t = ((64'd16 * 64'(k)) << 30) / 64'(TANH_DEPTH);
		n = t >> 30;
		f = t & 64'h3FFF_FFFF;
		acc = 64'd1073741824;
		term = 64'd1073741824;
		for (i = 1; i < 40 && term != 0; i++) begin
			term = ((term * f) >> 30) / i;
			if (i[0])
				acc = acc - term;
			else
				acc = acc + term;
		end
		e = acc;
		for (i = 0; i < n; i++)
			e = (e * 64'd395007542) >> 30;
		num = (64'd1073741824 - e) << 16;
		den = 64'd1073741824 + e;
		return int'((num + den / 2) / den);
	endfunction

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint tanh_q16(longint x);
		longint m, r;
		m = x < 0 ? -x : x;
		if (m >= (64'sd1 << 19))
			r = ONE_Q16;
		else
			r = tanh_lut[(m * TANH_DEPTH) >>> 19];
		return x < 0 ? -r : r;
	endfunction

	function automatic longint slope(longint v);
		return ONE_Q16 - ((v * v) >>> 16);
	endfunction

	function automatic longint next_vel(longint vel, longint g);
		return clampl(((mom_q16 * vel) >>> 16) + g, -64'sd8388608, 64'sd8388607);
	endfunction

	function automatic void net_step(logic [1:0] op, logic [SLOT_W-1:0] slot,
			logic signed [DW-1:0] val, logic signed [REW_W-1:0] rew);
		int a;
		longint acc, sr, p, g;
		net_out_t r;
		a = slot;
		fresh_outputs.delete();
		if (op == OP_LOAD) begin
			if (a < W2_BASE)
				w1[a] = val;
			else if (a < B1_BASE)
				w2[a - W2_BASE] = val;
			else if (a < B2_BASE)
				b1[a - B1_BASE] = val;
			else if (a < W_TOTAL)
				b2[a - B2_BASE] = val;
		end else if (op == OP_FEATURE && a < N_INPUTS) begin
			x_in[a] = val;
			if (a == N_INPUTS - 1) begin
				for (int h = 0; h < N_HIDDEN; h++) begin
					acc = b1[h] * ONE_Q16;
					for (int i = 0; i < N_INPUTS; i++)
						acc += x_in[i] * w1[i * N_HIDDEN + h];
					hid[h] = tanh_q16(acc >>> 16);
				end
				for (int o = 0; o < N_OUTPUTS; o++) begin
					acc = b2[o] * ONE_Q16;
					for (int h = 0; h < N_HIDDEN; h++)
						acc += hid[h] * w2[h * N_OUTPUTS + o];
					act[o] = tanh_q16(acc >>> 16);
					r.idx = o;
					r.val = act[o];
					r.last = (o == N_OUTPUTS - 1);
					fresh_outputs = {fresh_outputs, r};
				end
			end
		end else if (op == OP_LEARN) begin
			sr = (longint'(rew) * rate_q16) >>> 8;
			for (int h = 0; h < N_HIDDEN; h++) begin
				p = (sr * hid[h]) >>> 16;
				for (int o = 0; o < N_OUTPUTS; o++) begin
					g = (p * slope(act[o])) >>> 16;
					v2[h * N_OUTPUTS + o] = next_vel(v2[h * N_OUTPUTS + o], g);
					w2[h * N_OUTPUTS + o] = clampl(w2[h * N_OUTPUTS + o] +
						v2[h * N_OUTPUTS + o], -W_LIMIT, W_LIMIT);
				end
			end
			for (int i = 0; i < N_INPUTS; i++) begin
				p = (sr * x_in[i]) >>> 16;
				for (int h = 0; h < N_HIDDEN; h++) begin
					g = (p * slope(hid[h])) >>> 16;
					g = (g * TENTH_Q16) >>> 16;
					v1[i * N_HIDDEN + h] = next_vel(v1[i * N_HIDDEN + h], g);
					w1[i * N_HIDDEN + h] = clampl(w1[i * N_HIDDEN + h] +
						v1[i * N_HIDDEN + h], -W_LIMIT, W_LIMIT);
				end
			end
		end
	endfunction

	function automatic void note_error(string msg);
		if (errors < 10)
			$display("mismatch: %s", msg);
		errors++;
	endfunction

	task automatic send_req(logic [1:0] op, int slot, int val, int rew, bit zero_out);
		int gap;
		net_out_t r;
		gap = 0;
		while ($urandom_range(99) < in_idle_pct && gap < 40)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.slot <= slot[SLOT_W-1:0];
		in_ch.value <= val[DW-1:0];
		in_ch.reward <= rew[REW_W-1:0];
		do
			@(posedge clk);
		while (!in_ch.ready);
		net_step(op, slot[SLOT_W-1:0], val[DW-1:0], rew[REW_W-1:0]);
		n_reqs++;
		if (op == OP_LEARN)
			n_learns++;
		if (fresh_outputs.size() != 0)
			n_passes++;
		foreach (fresh_outputs[k]) begin
			r = fresh_outputs[k];
			if (zero_out)
				r.val = '0;
			pending_outputs = {pending_outputs, r};
		end
	endtask

	task automatic hold_input();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	task automatic settle();
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(int unsigned rate, int unsigned mom);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LEARN_RATE;
		cfg_data <= rate[CFG_W-1:0];
		@(negedge clk);
		cfg_index <= CFG_MOMENTUM;
		cfg_data <= mom[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		rate_q16 = rate & 16'hFFFF;
		mom_q16 = mom & 16'hFFFF;
	endtask

	function automatic int pick_value();
		if ($urandom_range(3) == 0)
			return int'($urandom);
		return int'($urandom_range(262143)) - 131072;
	endfunction

	function automatic int pick_reward();
		if ($urandom_range(1) == 0)
			return int'($urandom);
		return int'($urandom_range(4095)) - 2048;
	endfunction

	always @(negedge clk)
		out_ch.ready <= ($urandom_range(99) >= out_stall_pct);

	always @(posedge clk) begin
		net_out_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_outputs++;
			if (pending_outputs.size() == 0) begin
				note_error($sformatf("unexpected output idx %0d val %0d",
					out_ch.out_index, out_ch.out_value));
			end else begin
				e = pending_outputs.pop_front();
				if (out_ch.out_index !== e.idx || out_ch.out_value !== e.val ||
						out_ch.last_out !== e.last)
					note_error($sformatf("exp idx %0d val %0d last %0d, got %0d %0d %0d",
						e.idx, e.val, e.last, out_ch.out_index, out_ch.out_value,
						out_ch.last_out));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t rows[16];
		int r;
		rows = '{
			'{OP_FEATURE, N_INPUTS - 1, 0, 0, 1'b1},
			'{OP_LOAD, B2_BASE, 8388607, 0, 1'b0},
			'{OP_LOAD, W_TOTAL - 1, -8388608, 0, 1'b0},
			'{OP_LOAD, 511, 1234, 0, 1'b0},
			'{OP_LOAD, 0, 8388607, 0, 1'b0},
			'{OP_LOAD, B1_BASE, 65536, 0, 1'b0},
			'{OP_FEATURE, 0, -8388608, 0, 1'b0},
			'{OP_FEATURE, N_INPUTS, 555, 0, 1'b0},
			'{OP_FEATURE, 511, 777, 0, 1'b0},
			'{OP_JUNK, 0, 999, 16777215, 1'b0},
			'{OP_FEATURE, N_INPUTS - 1, 8388607, 0, 1'b0},
			'{OP_LEARN, 0, 0, 16777215, 1'b0},
			'{OP_LEARN, 0, 0, -16777216, 1'b0},
			'{OP_LEARN, 0, 0, 0, 1'b0},
			'{OP_FEATURE, N_INPUTS - 1, -65536, 0, 1'b0},
			'{OP_LEARN, 511, 0, 256, 1'b0}
		};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LEARN_RATE;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_LOAD;
		in_ch.slot = '0;
		in_ch.value = '0;
		in_ch.reward = '0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		errors = 0;
		n_reqs = 0;
		n_outputs = 0;
		n_passes = 0;
		n_learns = 0;
		rate_q16 = 655;
		mom_q16 = 58982;
		for (int k = 0; k < TANH_DEPTH; k++)
			tanh_lut[k] = tanh_point(k);
		foreach (w1[k]) begin w1[k] = 0; v1[k] = 0; end
		foreach (w2[k]) begin w2[k] = 0; v2[k] = 0; end
		foreach (b1[k]) begin b1[k] = 0; hid[k] = 0; end
		foreach (b2[k]) begin b2[k] = 0; act[k] = 0; end
		foreach (x_in[k]) x_in[k] = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every weight and bias defined before any use
		for (int a = 0; a < W_TOTAL; a++)
			send_req(OP_LOAD, a, 0, 0, 1'b0);
		foreach (rows[k])
			send_req(rows[k].op, rows[k].slot, rows[k].value, rows[k].reward,
				rows[k].zero_out);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin in_idle_pct = 0; out_stall_pct = 0; end
				1: begin in_idle_pct = 75; out_stall_pct = 0; end
				2: begin in_idle_pct = 0; out_stall_pct = 75; end
				default: begin in_idle_pct = 14; out_stall_pct = 14; end
			endcase
			hold_input();
			settle();
			case (ph)
				0: write_regs(655, 58982);
				1: write_regs(65535, 0);
				2: write_regs(0, 65535);
				default: write_regs($urandom_range(65535), $urandom_range(65535));
			endcase
			// a few fresh weights so learn steps do not sit at the clamps
			for (int k = 0; k < 6; k++)
				send_req(OP_LOAD, $urandom_range(W_TOTAL - 1), pick_value(), 0, 1'b0);
			r = 0;
			while (r < PHASE_REQS) begin
				case ($urandom_range(99)) inside
					[0:29]: begin
						for (int i = 0; i < N_INPUTS; i++)
							send_req(OP_FEATURE, i, pick_value(), pick_reward(), 1'b0);
						r += N_INPUTS;
					end
					[30:49]: begin
						send_req(OP_FEATURE, $urandom_range(N_INPUTS - 1), pick_value(),
							pick_reward(), 1'b0);
						r++;
					end
					[50:59]: begin
						send_req(OP_LEARN, $urandom_range(511), pick_value(),
							pick_reward(), 1'b0);
						r++;
					end
					[60:89]: begin
						send_req(OP_LOAD, $urandom_range(511), pick_value(), 0, 1'b0);
						r++;
					end
					default: begin
						if ($urandom_range(1) == 0)
							send_req(OP_JUNK, $urandom_range(511), pick_value(),
								pick_reward(), 1'b0);
						else
							send_req(OP_FEATURE, $urandom_range(511, N_INPUTS),
								pick_value(), pick_reward(), 1'b0);
						r++;
					end
				endcase
			end
		end
		hold_input();
		settle();

		$display("covered %0d requests: %0d forward passes, %0d learn steps, %0d outputs",
			n_reqs, n_passes, n_learns, n_outputs);
		$display("four idle patterns, register extremes, %0d mismatches", errors);
		if (errors == 0 && pending_outputs.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
